[hw/rtl/consecutive_run_tracker_top_defines.svh]
// Assertion macros for the consecutive run tracker.
// Included by files that carry concurrent assertions; depends on clk and rst_n in scope.
`ifndef CONSECUTIVE_RUN_TRACKER_TOP_DEFINES_SVH
`define CONSECUTIVE_RUN_TRACKER_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
// Checked only while out of reset.
`define CRT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked at every edge, reset included.
`define CRT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CRT_ASSERT(lbl, prop, msg)
`define CRT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

[hw/rtl/crt_pkg.sv]
// Shared types and constants for the consecutive run tracker.
// Used by crt_table, consecutive_run_tracker_top and the testbench; no dependencies.
package crt_pkg;

    localparam int KEY_BITS  = 10;
    localparam int LEN_BITS  = KEY_BITS + 1;

    typedef logic [KEY_BITS-1:0] key_t;
    typedef logic [LEN_BITS-1:0] len_t;

    // Command codes.
    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    localparam key_t KEY_MAX = {KEY_BITS{1'b1}};

    // One table entry: present mark plus the run ends.
    typedef struct packed {
        logic present;
        key_t head;
        key_t tail;
    } entry_t;

    // One access to the single-ported table, with per-field write enables.
    typedef struct packed {
        logic   we_present;
        logic   we_head;
        logic   we_tail;
        key_t   addr;
        entry_t wdata;
    } mem_req_t;

endpackage

[hw/rtl/consecutive_run_tracker_top.sv]
// Top level of the consecutive run tracker: sequencer, run merge and best length.
// Depends on crt_pkg, crt_table and consecutive_run_tracker_top_defines.svh.
//
// Channel  | Handshake          | Payload
// ---------+--------------------+----------------------------------------
// input    | start && !busy     | command, key
// result   | done (one cycle)   | best_length, run_length, duplicate
//
// An insert runs three reads and three writes through the single table port
// before the next accept can be taken. A duplicate key is reported once the
// entries of the key and its left neighbour are back. A clear sweeps the table,
// one entry a cycle, and then reports. After reset the same sweep runs with
// busy high and no result. The receiver cannot stall: each result shows for
// exactly one cycle.
`include "consecutive_run_tracker_top_defines.svh"
module consecutive_run_tracker_top (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          command,
    input  crt_pkg::key_t key,
    output logic          busy,
    output logic          done,
    output crt_pkg::len_t best_length,
    output crt_pkg::len_t run_length,
    output logic          duplicate
);
    import crt_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CLEAR = 7'b0000010,
        ST_RD_L  = 7'b0000100,
        ST_RD_R  = 7'b0001000,
        ST_MERGE = 7'b0010000,
        ST_WR_T  = 7'b0100000,
        ST_WR_H  = 7'b1000000
    } state_t;

    state_t   state_reg, state_next;
    key_t     sweep_reg, sweep_next;
    logic     report_reg, report_next;
    len_t     best_reg, best_next;
    logic     done_reg, done_next;
    len_t     best_out_reg, best_out_next;
    len_t     run_out_reg, run_out_next;
    logic     dup_out_reg, dup_out_next;
    key_t     key_reg, key_next;
    logic     present_k_reg, present_k_next;
    key_t     head_reg, head_next;
    key_t     tail_reg, tail_next;
    mem_req_t req;
    entry_t   rdata;
    len_t     len;

    crt_table u_table (
        .clk   (clk),
        .req   (req),
        .rdata (rdata)
    );

    // Length of the merged run.
    assign len = {1'b0, tail_reg} - {1'b0, head_reg} + len_t'(1);

    // Sequencer: table accesses and result formation.
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        report_next    = report_reg;
        best_next      = best_reg;
        done_next      = 1'b0;
        best_out_next  = best_out_reg;
        run_out_next   = run_out_reg;
        dup_out_next   = dup_out_reg;
        key_next       = key_reg;
        present_k_next = present_k_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        req            = '0;
        req.addr       = key;

        unique case (state_reg)
            ST_IDLE:
            begin
                // The read of the key itself is issued in the accept cycle.
                if (start)
                begin
                    key_next = key;
                    if (command == CMD_CLEAR)
                    begin
                        sweep_next  = '0;
                        report_next = 1'b1;
                        state_next  = ST_CLEAR;
                    end
                    else
                    begin
                        state_next = ST_RD_L;
                    end
                end
            end
            ST_CLEAR:
            begin
                // Clear one present mark a cycle.
                req.addr       = sweep_reg;
                req.we_present = 1'b1;
                sweep_next     = sweep_reg + key_t'(1);
                if (sweep_reg == KEY_MAX)
                begin
                    best_next  = '0;
                    state_next = ST_IDLE;
                    if (report_reg)
                    begin
                        done_next     = 1'b1;
                        best_out_next = '0;
                        run_out_next  = '0;
                        dup_out_next  = 1'b0;
                    end
                end
            end
            ST_RD_L:
            begin
                // Entry of the key is back; ask for the left neighbour.
                present_k_next = rdata.present;
                req.addr       = key_reg - key_t'(1);
                state_next     = ST_RD_R;
            end
            ST_RD_R:
            begin
                // Entry of the left neighbour is back; ask for the right one.
                req.addr = key_reg + key_t'(1);
                if ((key_reg != '0) && rdata.present)
                begin
                    head_next = rdata.head;
                end
                else
                begin
                    head_next = key_reg;
                end
                if (present_k_reg)
                begin
                    done_next     = 1'b1;
                    best_out_next = best_reg;
                    run_out_next  = '0;
                    dup_out_next  = 1'b1;
                    state_next    = ST_IDLE;
                end
                else
                begin
                    state_next = ST_MERGE;
                end
            end
            ST_MERGE:
            begin
                // Right neighbour is back; write the new key's entry.
                if ((key_reg != KEY_MAX) && rdata.present)
                begin
                    tail_next = rdata.tail;
                end
                else
                begin
                    tail_next = key_reg;
                end
                req.addr          = key_reg;
                req.we_present    = 1'b1;
                req.we_head       = 1'b1;
                req.we_tail       = 1'b1;
                req.wdata.present = 1'b1;
                req.wdata.head    = head_reg;
                req.wdata.tail    = tail_next;
                state_next        = ST_WR_T;
            end
            ST_WR_T:
            begin
                // The run's tail entry learns the new head.
                req.addr       = tail_reg;
                req.we_head    = 1'b1;
                req.wdata.head = head_reg;
                state_next     = ST_WR_H;
            end
            ST_WR_H:
            begin
                // The run's head entry learns the new tail; report.
                req.addr       = head_reg;
                req.we_tail    = 1'b1;
                req.wdata.tail = tail_reg;
                if (len > best_reg)
                begin
                    best_next = len;
                end
                done_next     = 1'b1;
                best_out_next = best_next;
                run_out_next  = len;
                dup_out_next  = 1'b0;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state, cleared by reset; the sweep runs first.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            sweep_reg  <= '0;
            report_reg <= 1'b0;
            best_reg   <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            sweep_reg  <= sweep_next;
            report_reg <= report_next;
            best_reg   <= best_next;
            done_reg   <= done_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        best_out_reg  <= best_out_next;
        run_out_reg   <= run_out_next;
        dup_out_reg   <= dup_out_next;
        key_reg       <= key_next;
        present_k_reg <= present_k_next;
        head_reg      <= head_next;
        tail_reg      <= tail_next;
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign best_length = best_out_reg;
    assign run_length  = run_out_reg;
    assign duplicate   = dup_out_reg;

    // A result is only shown once the sequencer is back at rest.
    `CRT_ASSERT(a_done_idle, !done || !busy, "result strobe while busy")
    // An accepted transaction always leaves the block busy.
    `CRT_ASSERT(a_accept_busy, start && !busy |=> busy, "accepted transaction not started")
    // A duplicate reports no run.
    `CRT_ASSERT(a_dup_run, done && duplicate |-> run_length == '0, "duplicate with a run")
    // The best length never falls below a freshly reported run.
    `CRT_ASSERT(a_best_cover, done && !duplicate |-> best_length >= run_length,
        "best length below run length")

endmodule

[hw/rtl/crt_table.sv]
// Single-ported key table with per-field write enables and registered read data.
// Depends on crt_pkg for the entry and request types.
module crt_table (
    input  logic              clk,
    input  crt_pkg::mem_req_t req,
    output crt_pkg::entry_t   rdata
);
    import crt_pkg::*;

    localparam int DEPTH = 1 << KEY_BITS;

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    // Write the enabled fields; otherwise read the addressed entry.
    always_ff @(posedge clk)
    begin
        if (req.we_present || req.we_head || req.we_tail)
        begin
            if (req.we_present)
            begin
                mem[req.addr].present <= req.wdata.present;
            end
            if (req.we_head)
            begin
                mem[req.addr].head <= req.wdata.head;
            end
            if (req.we_tail)
            begin
                mem[req.addr].tail <= req.wdata.tail;
            end
        end
        else
        begin
            rdata_reg <= mem[req.addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps
// Self-checking testbench for consecutive_run_tracker_top: it tracks the key set in its own
// model, predicts every result and compares each strobed result with the oldest prediction.
// Depends on crt_pkg and the RTL of the consecutive run tracker; needs nothing else.
module testbench;
    import crt_pkg::*;

    localparam int KEY_COUNT   = 1 << KEY_BITS;
    localparam int MAX_REPORTS = 10;

    // What one result transaction is expected to carry.
    typedef struct packed {
        len_t best_length;
        len_t run_length;
        logic duplicate;
    } run_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic command = CMD_INSERT;
    key_t key = '0;
    logic busy;
    logic done;
    len_t best_length;
    len_t run_length;
    logic duplicate;

    // Model of the key set: present marks, run ends and the best length so far.
    logic key_seen [KEY_COUNT];
    key_t head_of [KEY_COUNT];
    key_t tail_of [KEY_COUNT];
    len_t best_run;

    run_result_t expected_runs[$];
    int failures = 0;
    bit idle_enabled = 1'b0;

    consecutive_run_tracker_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .command     (command),
        .key         (key),
        .busy        (busy),
        .done        (done),
        .best_length (best_length),
        .run_length  (run_length),
        .duplicate   (duplicate)
    );

    always #5 clk = ~clk;

    // Applies one command to the model and returns the result it must produce.
    function automatic run_result_t predict_run(logic cmd, key_t k);
        run_result_t r;
        key_t lo;
        key_t hi;
        len_t len;
        r = '0;
        if (cmd == CMD_CLEAR)
        begin
            for (int i = 0; i < KEY_COUNT; i++)
                key_seen[i] = 1'b0;
            best_run = '0;
            return r;
        end
        if (key_seen[k])
        begin
            r.best_length = best_run;
            r.duplicate = 1'b1;
            return r;
        end
        // Join the run ending just below with the run starting just above.
        lo = k;
        hi = k;
        if (k != '0 && key_seen[k - key_t'(1)])
            lo = head_of[k - key_t'(1)];
        if (k != KEY_MAX && key_seen[k + key_t'(1)])
            hi = tail_of[k + key_t'(1)];
        key_seen[k] = 1'b1;
        head_of[k] = lo;
        tail_of[k] = hi;
        head_of[hi] = lo;
        tail_of[lo] = hi;
        len = len_t'(hi) - len_t'(lo) + len_t'(1);
        if (len > best_run)
            best_run = len;
        r.best_length = best_run;
        r.run_length = len;
        return r;
    endfunction

    // Mostly no gap, some short ones and the odd long one.
    function automatic int pick_gap();
        int r;
        if (!idle_enabled)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Presents one transaction and records its prediction once it is accepted.
    // Start is left high so that back-to-back transactions need no gap.
    task automatic send_transaction(logic cmd, key_t k);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        command <= cmd;
        key <= k;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        expected_runs.push_back(predict_run(cmd, k));
    endtask

    // Holds the sender off until every outstanding result has been seen.
    task automatic wait_for_results();
        start <= 1'b0;
        while (expected_runs.size() != 0)
            @(posedge clk);
    endtask

    task automatic compare_field(string name, int unsigned want, int unsigned got);
        if (want != got)
        begin
            failures++;
            if (failures <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    // Checks every strobed result against the oldest prediction.
    always @(posedge clk)
    begin
        run_result_t want;
        if (rst_n && done)
        begin
            if (expected_runs.size() == 0)
            begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: best %0d run %0d dup %0b",
                             $time, best_length, run_length, duplicate);
            end
            else
            begin
                want = expected_runs.pop_front();
                compare_field("best_length", 32'(want.best_length), 32'(best_length));
                compare_field("run_length", 32'(want.run_length), 32'(run_length));
                compare_field("duplicate", 32'(want.duplicate), 32'(duplicate));
            end
        end
    end

    // Range edges, merges from either side and both, duplicates and clears.
    task automatic test_directed();
        idle_enabled = 1'b1;
        send_transaction(CMD_INSERT, '0);
        send_transaction(CMD_INSERT, KEY_MAX);
        send_transaction(CMD_INSERT, '0);
        send_transaction(CMD_INSERT, key_t'(KEY_MAX - 1));
        send_transaction(CMD_INSERT, key_t'(2));
        send_transaction(CMD_INSERT, key_t'(1));
        send_transaction(CMD_INSERT, key_t'(KEY_MAX - 2));
        send_transaction(CMD_INSERT, key_t'(KEY_MAX - 2));
        send_transaction(CMD_INSERT, key_t'('h2AA));
        send_transaction(CMD_INSERT, key_t'('h155));
        send_transaction(CMD_CLEAR, KEY_MAX);
        send_transaction(CMD_INSERT, key_t'(1));
        send_transaction(CMD_INSERT, '0);
        send_transaction(CMD_CLEAR, '0);
        send_transaction(CMD_CLEAR, key_t'('h155));
        send_transaction(CMD_INSERT, key_t'(KEY_COUNT / 2));
        send_transaction(CMD_INSERT, key_t'(KEY_COUNT / 2 - 1));
        send_transaction(CMD_INSERT, key_t'(KEY_COUNT / 2 + 1));
        send_transaction(CMD_INSERT, key_t'(KEY_COUNT / 2 - 1));
    endtask

    // Every key in shuffled order, so the set ends as a single run of full length.
    task automatic test_full_table();
        key_t order [KEY_COUNT];
        key_t held;
        int j;
        for (int i = 0; i < KEY_COUNT; i++)
            order[i] = key_t'(i);
        for (int i = KEY_COUNT - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            held = order[i];
            order[i] = order[j];
            order[j] = held;
        end
        send_transaction(CMD_CLEAR, key_t'($urandom));
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            if (i % 128 == 0)
                idle_enabled = ($urandom_range(0, 2) != 0);
            send_transaction(CMD_INSERT, order[i]);
        end
        wait_for_results();
        send_transaction(CMD_INSERT, '0);
        send_transaction(CMD_INSERT, KEY_MAX);
        send_transaction(CMD_CLEAR, key_t'($urandom));
    endtask

    // Bursts of keys drawn from narrow windows so that runs grow and merge,
    // mixed with keys from the whole range and the occasional clear.
    task automatic test_random_windows(int count);
        int base;
        int width;
        int r;
        int sent;
        sent = 0;
        while (sent < count)
        begin
            width = $urandom_range(4, 64);
            case ($urandom_range(0, 3))
                0: base = 0;
                1: base = KEY_COUNT - width;
                default: base = $urandom_range(0, KEY_COUNT - width);
            endcase
            idle_enabled = ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 1) == 1)
            begin
                send_transaction(CMD_CLEAR, key_t'($urandom));
                sent++;
            end
            repeat ($urandom_range(20, 80))
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    send_transaction(CMD_INSERT, key_t'($urandom));
                else if (r < 12)
                    send_transaction(CMD_CLEAR, key_t'($urandom));
                else
                    send_transaction(CMD_INSERT, key_t'(base + $urandom_range(0, width - 1)));
                sent++;
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < KEY_COUNT; i++)
        begin
            key_seen[i] = 1'b0;
            head_of[i] = '0;
            tail_of[i] = '0;
        end
        best_run = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_table();
        test_random_windows(460);

        // Let the last results through and watch for any stray strobe.
        wait_for_results();
        repeat (20) @(posedge clk);
        if (failures == 0 && expected_runs.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // Watchdog for a block that stops answering.
    initial
    begin
        #5_000_000;
        $display("testbench failed");
        $finish;
    end

endmodule
